### rtl/double_hash_key_value_table_defines.svh
// ----------------------------------------------------------------------------
// Double hash key/value table - assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_HASH_KEY_VALUE_TABLE_DEFINES_SVH
`define DOUBLE_HASH_KEY_VALUE_TABLE_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define DHKVT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Same-cycle implication.
`define DHKVT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	`DHKVT_PROP(lbl, clk, rst_n, (ante) |-> (cons), msg)

// Next-cycle implication.
`define DHKVT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	`DHKVT_PROP(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

### rtl/dhkvt_pkg.sv
// ----------------------------------------------------------------------------
// Double hash key/value table - package
// Sizes, reciprocal constants, command codes, transaction types and helpers.
// ----------------------------------------------------------------------------
package dhkvt_pkg;

	localparam int TABLE_SIZE  = 1021;
	localparam int KEY_BYTES   = 10;
	localparam int NBYTES      = 10;
	localparam int STR_W       = 8 * NBYTES;
	localparam int IDX_W       = $clog2(TABLE_SIZE);
	localparam int CNT_W       = $clog2(TABLE_SIZE + 1);
	localparam int COUNT_OUT_W = 10;
	localparam int STEP_MOD    = TABLE_SIZE - 2;

	// Modulo by constant: q = (h * floor(2^SHIFT / d)) >> SHIFT is exact or one low.
	localparam int RECIP_SHIFT = 40;
	localparam int RECIP_W     = RECIP_SHIFT + 1 - $clog2(STEP_MOD);
	localparam int PROD_W      = 32 + RECIP_W;
	localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
	localparam logic [RECIP_W-1:0] RECIP_HOME =
		RECIP_W'((64'd1 << RECIP_SHIFT) / TABLE_SIZE);
	localparam logic [RECIP_W-1:0] RECIP_STEP =
		RECIP_W'((64'd1 << RECIP_SHIFT) / STEP_MOD);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_LOOKUP = 2'd1;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;
	localparam logic [1:0] FUNC_NOP    = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] key_high;
		logic [63:0] key_low;
		logic [15:0] value_high;
		logic [63:0] value_low;
	} cmd_t;

	typedef struct packed {
		logic                   found;
		logic                   status;
		logic [15:0]            result_high;
		logic [63:0]            result_low;
		logic [COUNT_OUT_W-1:0] stored_count;
	} rsp_t;

	// Zero every byte after the first zero byte and past KEY_BYTES.
	function automatic logic [STR_W-1:0] canon(logic [STR_W-1:0] raw);
		logic [STR_W-1:0] res;
		logic [7:0]       b;
		logic             ended;
		res   = '0;
		ended = 1'b0;
		for (int i = 0; i < NBYTES; i++) begin
			b = raw[STR_W-1-8*i -: 8];
			if (ended || i >= KEY_BYTES)
				b = 8'd0;
			if (b == 8'd0)
				ended = 1'b1;
			res[STR_W-1-8*i -: 8] = b;
		end
		return res;
	endfunction

	// Fold five bytes of a canonical string into a shift-add hash.
	function automatic logic [31:0] hash5(logic [31:0] h, logic [39:0] bytes,
		logic [1:0] sh);
		logic [31:0] acc;
		logic [7:0]  b;
		acc = h;
		for (int i = 0; i < 5; i++) begin
			b = bytes[39-8*i -: 8];
			if (b != 8'd0)
				acc = (acc << sh) + 32'(b);
		end
		return acc;
	endfunction

endpackage

### rtl/double_hash_key_value_table.sv
// ----------------------------------------------------------------------------
// Double hash key/value table
// Open-addressing key/value store with double hashing, held in on-chip RAM.
// ----------------------------------------------------------------------------
//  channel  | handshake        | payload           | direction
//  ---------+------------------+-------------------+----------
//  command  | start / busy     | cmd   (cmd_t)     | in
//  response | done (one cycle) | rsp   (rsp_t)     | out
//
//  Insert and lookup pass through HASH0, HASH1, MOD0, MOD1, MOD2 and READ,
//  then probe one slot per PROBE state (one RAM read per probe through the
//  read port). Clear sweeps every slot (one slot-used write per cycle); the
//  unused code answers in the next cycle. After reset the same sweep runs
//  with busy high. A response is shown for one cycle and a new transaction
//  may be accepted in that same cycle.
// ----------------------------------------------------------------------------
module double_hash_key_value_table (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  dhkvt_pkg::cmd_t   cmd,
	output logic              done,
	output dhkvt_pkg::rsp_t   rsp
);

	typedef enum logic [9:0] {
		ST_INIT  = 10'b00_0000_0001,
		ST_IDLE  = 10'b00_0000_0010,
		ST_HASH0 = 10'b00_0000_0100,
		ST_HASH1 = 10'b00_0000_1000,
		ST_MOD0  = 10'b00_0001_0000,
		ST_MOD1  = 10'b00_0010_0000,
		ST_MOD2  = 10'b00_0100_0000,
		ST_READ  = 10'b00_1000_0000,
		ST_PROBE = 10'b01_0000_0000,
		ST_CLEAR = 10'b10_0000_0000
	} state_t;

	localparam int IDX_W  = dhkvt_pkg::IDX_W;
	localparam int STR_W  = dhkvt_pkg::STR_W;
	localparam int PROD_W = dhkvt_pkg::PROD_W;

	state_t                        state_q, state_d;
	logic [1:0]                    func_q;
	logic [STR_W-1:0]              key_q, val_q;
	logic [31:0]                   h1_q, h2_q;
	logic [PROD_W-1:0]             p1_q, p2_q;
	logic [31:0]                   qd1_q, qd2_q;
	logic [IDX_W-1:0]              addr_q, step_q, n_q, sw_q;
	logic [dhkvt_pkg::CNT_W-1:0]   count_q, count_d;
	logic                          done_q;
	dhkvt_pkg::rsp_t               rsp_q;

	logic                          used_mem [dhkvt_pkg::TABLE_SIZE];
	logic [2*STR_W-1:0]            data_mem [dhkvt_pkg::TABLE_SIZE];
	logic                          used_rd_q;
	logic [2*STR_W-1:0]            data_rd_q;

	logic                          accept;
	logic                          fin, fin_found, fin_status, adv, ins_wr, sw_wr;
	logic                          key_eq, last;
	logic [IDX_W:0]                sum;
	logic [IDX_W-1:0]              next_addr, rd_addr;
	logic [31:0]                   r1, r2, home_full, step_full;
	logic [IDX_W-1:0]              step_mod;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign rsp    = rsp_q;

	assign key_eq    = (data_rd_q[2*STR_W-1:STR_W] == key_q);
	assign last      = (n_q == dhkvt_pkg::LAST_IDX);
	assign sum       = {1'b0, addr_q} + {1'b0, step_q};
	assign next_addr = (sum >= (IDX_W+1)'(dhkvt_pkg::TABLE_SIZE)) ?
		IDX_W'(sum - (IDX_W+1)'(dhkvt_pkg::TABLE_SIZE)) : IDX_W'(sum);
	assign rd_addr   = (state_q == ST_PROBE) ? next_addr : addr_q;

	assign r1        = h1_q - qd1_q;
	assign r2        = h2_q - qd2_q;
	assign home_full = (r1 >= 32'(dhkvt_pkg::TABLE_SIZE)) ?
		r1 - 32'(dhkvt_pkg::TABLE_SIZE) : r1;
	assign step_full = (r2 >= 32'(dhkvt_pkg::STEP_MOD)) ?
		r2 - 32'(dhkvt_pkg::STEP_MOD) : r2;
	assign step_mod  = IDX_W'(step_full);

	always_comb begin
		state_d    = state_q;
		fin        = 1'b0;
		fin_found  = 1'b0;
		fin_status = 1'b0;
		adv        = 1'b0;
		ins_wr     = 1'b0;
		sw_wr      = 1'b0;
		case (state_q)
			ST_INIT: begin
				sw_wr = 1'b1;
				if (sw_q == dhkvt_pkg::LAST_IDX)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					case (cmd.func)
						dhkvt_pkg::FUNC_INSERT: state_d = ST_HASH0;
						dhkvt_pkg::FUNC_LOOKUP: state_d = ST_HASH0;
						dhkvt_pkg::FUNC_CLEAR:  state_d = ST_CLEAR;
						default:                fin     = 1'b1;
					endcase
				end
			end
			ST_HASH0: state_d = ST_HASH1;
			ST_HASH1: state_d = ST_MOD0;
			ST_MOD0:  state_d = ST_MOD1;
			ST_MOD1:  state_d = ST_MOD2;
			ST_MOD2:  state_d = ST_READ;
			ST_READ:  state_d = ST_PROBE;
			ST_PROBE: begin
				if (func_q == dhkvt_pkg::FUNC_INSERT) begin
					if (!used_rd_q) begin
						ins_wr  = 1'b1;
						fin     = 1'b1;
						state_d = ST_IDLE;
					end else if (last) begin
						fin        = 1'b1;
						fin_status = 1'b1;
						state_d    = ST_IDLE;
					end else begin
						adv = 1'b1;
					end
				end else begin
					if (!used_rd_q) begin
						fin     = 1'b1;
						state_d = ST_IDLE;
					end else if (key_eq) begin
						fin       = 1'b1;
						fin_found = 1'b1;
						state_d   = ST_IDLE;
					end else if (last) begin
						fin     = 1'b1;
						state_d = ST_IDLE;
					end else begin
						adv = 1'b1;
					end
				end
			end
			ST_CLEAR: begin
				sw_wr = 1'b1;
				if (sw_q == dhkvt_pkg::LAST_IDX) begin
					fin     = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		count_d = count_q;
		if (accept && cmd.func == dhkvt_pkg::FUNC_CLEAR)
			count_d = '0;
		else if (ins_wr)
			count_d = count_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			sw_q    <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= fin;
			if (sw_wr)
				sw_q <= (sw_q == dhkvt_pkg::LAST_IDX) ? '0 : sw_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= cmd.func;
			key_q  <= dhkvt_pkg::canon({cmd.key_high, cmd.key_low});
			val_q  <= dhkvt_pkg::canon({cmd.value_high, cmd.value_low});
		end
		case (state_q)
			ST_HASH0: begin
				h1_q <= dhkvt_pkg::hash5(32'd0, key_q[STR_W-1 -: 40], 2'd3);
				h2_q <= dhkvt_pkg::hash5(32'd0, key_q[STR_W-1 -: 40], 2'd2);
			end
			ST_HASH1: begin
				h1_q <= dhkvt_pkg::hash5(h1_q, key_q[39:0], 2'd3);
				h2_q <= dhkvt_pkg::hash5(h2_q, key_q[39:0], 2'd2);
			end
			ST_MOD0: begin
				p1_q <= PROD_W'(h1_q) * PROD_W'(dhkvt_pkg::RECIP_HOME);
				p2_q <= PROD_W'(h2_q) * PROD_W'(dhkvt_pkg::RECIP_STEP);
			end
			ST_MOD1: begin
				qd1_q <= 32'(p1_q[PROD_W-1:dhkvt_pkg::RECIP_SHIFT]) *
					32'(dhkvt_pkg::TABLE_SIZE);
				qd2_q <= 32'(p2_q[PROD_W-1:dhkvt_pkg::RECIP_SHIFT]) *
					32'(dhkvt_pkg::STEP_MOD);
			end
			ST_MOD2: begin
				addr_q <= IDX_W'(home_full);
				step_q <= (step_mod == '0) ? IDX_W'(1) : step_mod;
				n_q    <= '0;
			end
			ST_PROBE: begin
				if (adv) begin
					addr_q <= next_addr;
					n_q    <= n_q + 1'b1;
				end
			end
			default: ;
		endcase
		if (fin) begin
			rsp_q.found        <= fin_found;
			rsp_q.status       <= fin_status;
			rsp_q.result_high  <= fin_found ? data_rd_q[79:64] : 16'd0;
			rsp_q.result_low   <= fin_found ? data_rd_q[63:0] : 64'd0;
			rsp_q.stored_count <= dhkvt_pkg::COUNT_OUT_W'(count_d);
		end
	end

	always_ff @(posedge clk) begin
		if (sw_wr || ins_wr)
			used_mem[ins_wr ? addr_q : sw_q] <= ins_wr;
		used_rd_q <= used_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ins_wr)
			data_mem[addr_q] <= {key_q, val_q};
		data_rd_q <= data_mem[rd_addr];
	end

endmodule

### rtl/dhkvt_chk.sv
// ----------------------------------------------------------------------------
// Double hash key/value table - port checker
// Watches the command and response ports of the table over time.
// ----------------------------------------------------------------------------
`include "double_hash_key_value_table_defines.svh"

module dhkvt_chk (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input dhkvt_pkg::cmd_t cmd,
	input logic            done,
	input dhkvt_pkg::rsp_t rsp
);

	`DHKVT_IMPLY(a_done_not_busy, clk, arst_n, done, !busy, "response while busy")
	`DHKVT_IMPLY(a_miss_zero, clk, arst_n, done && !rsp.found, rsp.result_high == 16'd0 && rsp.result_low == 64'd0, "miss carries data")
	`DHKVT_IMPLY(a_hit_ok, clk, arst_n, done && rsp.found, !rsp.status, "hit with full status")
	`DHKVT_NEXT(a_work_busy, clk, arst_n, start && !busy && cmd.func != dhkvt_pkg::FUNC_NOP, busy && !done, "accepted work not busy")
	`DHKVT_NEXT(a_nop_done, clk, arst_n, start && !busy && cmd.func == dhkvt_pkg::FUNC_NOP, done && !rsp.found && !rsp.status, "no-op transaction not answered")

endmodule

bind double_hash_key_value_table dhkvt_chk u_dhkvt_chk (.*);
